[rtl/cps_pkg.sv]
package cps_pkg;

    localparam int T_BITS            = 30;
    localparam int TAB_LEN           = 24;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam logic signed [33:0] ROT_X0 = 34'sd652032874;
    localparam logic signed [15:0] Q_MAX  = 16'sd16384;
    localparam logic signed [15:0] Q_MIN  = -16'sd16384;

    // One item as it travels down the pipeline; each stage fills in its part.
    typedef struct packed {
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [23:0] ex;
        logic signed [23:0] ey;
        logic signed [15:0] sh;
        logic signed [15:0] eh;
        logic               hfs;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic signed [24:0] qx;
        logic signed [24:0] qy;
        logic signed [49:0] pxx;
        logic signed [49:0] pyy;
        logic signed [49:0] pdx;
        logic signed [49:0] pdy;
        logic               deg;
        logic               tzero;
        logic               tone;
        logic [49:0]        l2;
        logic [49:0]        rem;
        logic [30:0]        t;
        logic signed [57:0] vx;
        logic signed [57:0] vy;
        logic [31:0]        vz;
        logic signed [15:0] hd;
        logic signed [33:0] rx;
        logic signed [33:0] ry;
        logic signed [33:0] rz;
        logic signed [55:0] ptx;
        logic signed [55:0] pty;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } item_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [31:0] atan_ang(input int i);
        logic [31:0] a;
        case (i)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10680862;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

[rtl/cps_cell.sv]
module cps_cell #(
    parameter int STEP   = 0,
    parameter bit DO_DIV = 1'b1,
    parameter bit DO_VEC = 1'b1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  cps_pkg::item_t  in_item,
    output logic            out_valid,
    output cps_pkg::item_t  out_item
);
    import cps_pkg::*;

    logic               valid_reg;
    item_t              item_reg;
    item_t              item_next;
    logic [50:0]        r2;
    logic [50:0]        diff;
    logic signed [57:0] xs;
    logic signed [57:0] ys;

    // Per cell, one restoring-division bit (when DO_DIV) and one vectoring rotation (when DO_VEC).
    always_comb
    begin
        item_next = in_item;
        r2        = {in_item.rem, 1'b0};
        diff      = r2 - {1'b0, in_item.l2};
        xs        = in_item.vx >>> STEP;
        ys        = in_item.vy >>> STEP;
        if (DO_DIV)
        begin
            if (r2 >= {1'b0, in_item.l2})
            begin
                item_next.rem = diff[49:0];
                item_next.t   = {in_item.t[29:0], 1'b1};
            end
            else
            begin
                item_next.rem = r2[49:0];
                item_next.t   = {in_item.t[29:0], 1'b0};
            end
        end
        if (DO_VEC)
        begin
            if (!in_item.vy[57])
            begin
                item_next.vx = in_item.vx + ys;
                item_next.vy = in_item.vy - xs;
                item_next.vz = in_item.vz + atan_ang(STEP);
            end
            else
            begin
                item_next.vx = in_item.vx - ys;
                item_next.vy = in_item.vy + xs;
                item_next.vz = in_item.vz - atan_ang(STEP);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/cps_rot_cell.sv]
module cps_rot_cell #(
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  cps_pkg::item_t  in_item,
    output logic            out_valid,
    output cps_pkg::item_t  out_item
);
    import cps_pkg::*;

    logic               valid_reg;
    item_t              item_reg;
    item_t              item_next;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] ang;

    // One rotation-mode step driving the half angle toward zero.
    always_comb
    begin
        item_next = in_item;
        xs        = in_item.rx >>> STEP;
        ys        = in_item.ry >>> STEP;
        ang       = $signed({2'b00, atan_ang(STEP)});
        if (!in_item.rz[33])
        begin
            item_next.rx = in_item.rx - ys;
            item_next.ry = in_item.ry + xs;
            item_next.rz = in_item.rz - ang;
        end
        else
        begin
            item_next.rx = in_item.rx + ys;
            item_next.ry = in_item.ry - xs;
            item_next.rz = in_item.rz + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/closest_pose_on_segment_core.sv]
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   point, start, end, headings
// out       output     out_valid / out_ready closest_x/y, heading, quat_z/w, degenerate
// cfg       input      cfg_valid / cfg_ready cfg_data = heading_from_segment
//
// One transaction enters per cycle while the pipeline advances; it passes stages A,
// B and C, the 30-cell divider/vectoring chain, stage H, the rotation chain, then
// stages M and F. Reset clears every stage valid and sets
// heading_from_segment to 1. The whole pipeline holds while the output register
// is full and not taken; in_ready follows that same advance condition.
module closest_pose_on_segment_core #(
    parameter int CORDIC_STAGES = cps_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [23:0] start_x,
    input  logic signed [23:0] start_y,
    input  logic signed [23:0] end_x,
    input  logic signed [23:0] end_y,
    input  logic signed [15:0] start_heading,
    input  logic signed [15:0] end_heading,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] closest_x,
    output logic signed [23:0] closest_y,
    output logic signed [15:0] heading,
    output logic signed [15:0] quat_z,
    output logic signed [15:0] quat_w,
    output logic               degenerate
);
    import cps_pkg::*;

    localparam int VEC_N = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int CHAIN = (VEC_N > T_BITS) ? VEC_N : T_BITS;

    function automatic logic signed [15:0] sat_q(input logic signed [33:0] v);
        logic signed [34:0] s;
        logic signed [34:0] r;
        logic signed [15:0] q;
        s = 35'(v) + 35'sd32768;
        r = s >>> 16;
        if (r > 35'(Q_MAX))
            q = Q_MAX;
        else if (r < 35'(Q_MIN))
            q = Q_MIN;
        else
            q = 16'(r);
        return q;
    endfunction

    function automatic logic signed [23:0] place(input logic signed [23:0] s,
                                                 input logic signed [55:0] p);
        logic signed [56:0] rs;
        logic signed [56:0] sh;
        logic signed [27:0] sum;
        logic signed [23:0] q;
        rs  = 57'(p) + 57'sd536870912;
        sh  = rs >>> T_BITS;
        sum = 28'(sh) + 28'(s);
        if (sum > 28'sd8388607)
            q = 24'sd8388607;
        else if (sum < -28'sd8388608)
            q = -24'sd8388608;
        else
            q = 24'(sum);
        return q;
    endfunction

    logic  adv;
    logic  hfs_reg;
    logic  a_v_reg, b_v_reg, c_v_reg, h_v_reg, m_v_reg, f_v_reg;
    item_t a_reg, b_reg, c_reg, h_reg, m_reg, f_reg;
    item_t a_next, b_next, c_next, h_next, m_next, f_next;
    logic signed [50:0] dot;
    logic [31:0]        hsum;
    logic [30:0]        tf;

    item_t chain_item  [CHAIN+1];
    logic  chain_valid [CHAIN+1];
    item_t rot_item    [VEC_N+1];
    logic  rot_valid   [VEC_N+1];

    // Advance everything when the output register is empty or being taken.
    assign adv       = !f_v_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hfs_reg <= 1'b1;
        else if (cfg_valid)
            hfs_reg <= cfg_data;
    end

    // Stage A: capture the transaction and form the differences.
    always_comb
    begin
        a_next     = '0;
        a_next.sx  = start_x;
        a_next.sy  = start_y;
        a_next.ex  = end_x;
        a_next.ey  = end_y;
        a_next.sh  = start_heading;
        a_next.eh  = end_heading;
        a_next.hfs = hfs_reg;
        a_next.dx  = 25'(end_x) - 25'(start_x);
        a_next.dy  = 25'(end_y) - 25'(start_y);
        a_next.qx  = 25'(point_x) - 25'(start_x);
        a_next.qy  = 25'(point_y) - 25'(start_y);
    end

    // Stage B: four products, registered.
    always_comb
    begin
        b_next     = a_reg;
        b_next.pxx = a_reg.dx * a_reg.dx;
        b_next.pyy = a_reg.dy * a_reg.dy;
        b_next.pdx = a_reg.qx * a_reg.dx;
        b_next.pdy = a_reg.qy * a_reg.dy;
    end

    // Stage C: squared length, dot product, clamp flags, chain start values.
    always_comb
    begin
        c_next       = b_reg;
        c_next.l2    = $unsigned(b_reg.pxx + b_reg.pyy);
        dot          = 51'(b_reg.pdx) + 51'(b_reg.pdy);
        c_next.deg   = (c_next.l2 == '0);
        c_next.tzero = dot[50] || (dot == '0);
        c_next.tone  = !c_next.tzero && (dot[49:0] >= c_next.l2);
        c_next.rem   = (c_next.tzero || c_next.tone) ? '0 : dot[49:0];
        c_next.t     = '0;
        c_next.vx    = 58'(b_reg.dx) <<< 30;
        c_next.vy    = 58'(b_reg.dy) <<< 30;
        c_next.vz    = '0;
        if (b_reg.dx[24])
        begin
            // Turn a left-pointing vector by pi before vectoring.
            c_next.vx = -(58'(b_reg.dx) <<< 30);
            c_next.vy = -(58'(b_reg.dy) <<< 30);
            c_next.vz = 32'h8000_0000;
        end
    end

    assign chain_item[0]  = c_reg;
    assign chain_valid[0] = c_v_reg;

    for (genvar k = 0; k < CHAIN; k++)
    begin : g_chain
        cps_cell #(
            .STEP   (k),
            .DO_DIV (k < T_BITS),
            .DO_VEC (k < VEC_N)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[k]),
            .in_item   (chain_item[k]),
            .out_valid (chain_valid[k+1]),
            .out_item  (chain_item[k+1])
        );
    end

    // Stage H: choose the yaw and load the rotation chain with the half angle.
    always_comb
    begin
        h_next = chain_item[CHAIN];
        hsum   = chain_item[CHAIN].vz + 32'h0000_8000;
        if (chain_item[CHAIN].deg)
            h_next.hd = chain_item[CHAIN].eh;
        else if (chain_item[CHAIN].hfs)
            h_next.hd = $signed(hsum[31:16]);
        else
            h_next.hd = chain_item[CHAIN].sh;
        h_next.rx = ROT_X0;
        h_next.ry = '0;
        h_next.rz = 34'(h_next.hd) <<< 15;
    end

    assign rot_item[0]  = h_reg;
    assign rot_valid[0] = h_v_reg;

    for (genvar k = 0; k < VEC_N; k++)
    begin : g_rot
        cps_rot_cell #(
            .STEP (k)
        ) u_rot (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (rot_valid[k]),
            .in_item   (rot_item[k]),
            .out_valid (rot_valid[k+1]),
            .out_item  (rot_item[k+1])
        );
    end

    // Stage M: scale the direction by t; round the quaternion parts.
    always_comb
    begin
        m_next = rot_item[VEC_N];
        if (rot_item[VEC_N].tzero)
            tf = '0;
        else if (rot_item[VEC_N].tone)
            tf = 31'(1) << T_BITS;
        else
            tf = rot_item[VEC_N].t;
        m_next.ptx = 56'($signed({1'b0, tf})) * 56'(rot_item[VEC_N].dx);
        m_next.pty = 56'($signed({1'b0, tf})) * 56'(rot_item[VEC_N].dy);
        m_next.qz  = sat_q(rot_item[VEC_N].ry);
        m_next.qw  = sat_q(rot_item[VEC_N].rx);
    end

    // Stage F: round, offset from the start, saturate; degenerate returns end.
    always_comb
    begin
        f_next    = m_reg;
        f_next.sx = m_reg.deg ? m_reg.ex : place(m_reg.sx, m_reg.ptx);
        f_next.sy = m_reg.deg ? m_reg.ey : place(m_reg.sy, m_reg.pty);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            h_v_reg <= chain_valid[CHAIN];
            m_v_reg <= rot_valid[VEC_N];
            f_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            h_reg <= h_next;
            m_reg <= m_next;
            f_reg <= f_next;
        end
    end

    assign out_valid  = f_v_reg;
    assign closest_x  = f_reg.sx;
    assign closest_y  = f_reg.sy;
    assign heading    = f_reg.hd;
    assign quat_z     = f_reg.qz;
    assign quat_w     = f_reg.qw;
    assign degenerate = f_reg.deg;

    // Clamp flags of the projection parameter exclude each other.
    assert property (@(posedge clk) disable iff (!rst_n)
        c_v_reg |-> !(c_reg.tzero && c_reg.tone))
        else $error("t clamped to both zero and one");

    // An advancing stage hands its transaction to the next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_v_reg && adv) |=> c_v_reg)
        else $error("transaction lost between product and sum stages");

    // Start heading selected on a real segment passes through unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (h_v_reg && !h_reg.hfs && !h_reg.deg) |-> (h_reg.hd == h_reg.sh))
        else $error("start heading not selected");

    // Quaternion parts stay within Q1.14 unit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_z <= Q_MAX && quat_z >= Q_MIN
                       && quat_w <= Q_MAX && quat_w >= Q_MIN))
        else $error("quaternion part out of range");

endmodule

[sim/tb_closest_pose_on_segment_core.sv]
`timescale 1ns / 1ps

module tb_closest_pose_on_segment_core;

    import cps_pkg::*;

    localparam int N_STAGES = (CORDIC_STAGES_DEF < TAB_LEN) ? CORDIC_STAGES_DEF : TAB_LEN;
    localparam int LATENCY  = ((T_BITS > N_STAGES) ? T_BITS : N_STAGES) + N_STAGES + 6;
    localparam int HOLD_CYCLES = 400;
    localparam longint C_MIN = -64'sd8388608;
    localparam longint C_MAX = 64'sd8388607;

    // atan(2^-i) in a 32-bit binary angle
    localparam logic [31:0] ARCTAN [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    typedef struct {
        logic signed [23:0] px, py, sx, sy, ex, ey;
        logic signed [15:0] sh, eh;
    } query_t;

    typedef struct {
        logic signed [23:0] cx, cy;
        logic signed [15:0] hd, qz, qw;
        logic               deg;
    } pose_t;

    // directed row: query, register setting, and hand-typed pose where obvious
    typedef struct {
        bit                 hfs;
        query_t             q;
        bit                 typed;
        logic signed [23:0] cx, cy;
        logic signed [15:0] hd;
        logic               deg;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] point_x, point_y, start_x, start_y, end_x, end_y;
    logic signed [15:0] start_heading, end_heading;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] closest_x, closest_y;
    logic signed [15:0] heading, quat_z, quat_w;
    logic               degenerate;

    pose_t pending_poses[$];
    bit    heading_sel;       // our copy of heading_from_segment
    int    err_count;
    int    tx_idle, rx_idle;
    int    hold_tok;

    closest_pose_on_segment_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .point_x       (point_x),
        .point_y       (point_y),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .start_heading (start_heading),
        .end_heading   (end_heading),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .closest_x     (closest_x),
        .closest_y     (closest_y),
        .heading       (heading),
        .quat_z        (quat_z),
        .quat_w        (quat_w),
        .degenerate    (degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // sin and cos of half the heading, rotation CORDIC, Q1.14
    function automatic void half_angle_quat(input longint hd, output longint qz,
                                            output longint qw);
        longint x, y, z, xs, ys;
        x = 64'sd652032874;
        y = 0;
        z = hd * 32768;
        for (int i = 0; i < N_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys; y = y + xs; z = z - longint'(ARCTAN[i]);
            end
            else
            begin
                x = x + ys; y = y - xs; z = z + longint'(ARCTAN[i]);
            end
        end
        qz = clip((y + 32768) >>> 16, -16384, 16384);
        qw = clip((x + 32768) >>> 16, -16384, 16384);
    endfunction

    // direction of (dx, dy) as a 32-bit binary angle, vectoring CORDIC
    function automatic logic [31:0] segment_angle(input longint dx, input longint dy);
        longint x, y, xs, ys;
        logic [31:0] z;
        x = dx * (64'sd1 <<< 30);
        y = dy * (64'sd1 <<< 30);
        z = 32'd0;
        if (x < 0)
        begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < N_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys; y = y - xs; z = z + ARCTAN[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - ARCTAN[i];
            end
        end
        return z;
    endfunction

    function automatic pose_t project_pose(input query_t q, input bit hfs);
        pose_t  p;
        longint dx, dy, l2, dot, t, r, hd, qz, qw;
        logic [31:0] zr;
        dx = longint'(q.ex) - longint'(q.sx);
        dy = longint'(q.ey) - longint'(q.sy);
        l2 = dx * dx + dy * dy;
        if (l2 == 0)
        begin
            p.cx  = q.ex;
            p.cy  = q.ey;
            hd    = longint'(q.eh);
            p.deg = 1'b1;
        end
        else
        begin
            dot = (longint'(q.px) - q.sx) * dx + (longint'(q.py) - q.sy) * dy;
            if (dot <= 0)
                t = 0;
            else if (dot >= l2)
                t = 64'sd1 <<< T_BITS;
            else
            begin
                r = dot;
                t = 0;
                for (int i = 0; i < T_BITS; i++)
                begin
                    r = r * 2;
                    t = t * 2;
                    if (r >= l2)
                    begin
                        r = r - l2;
                        t = t + 1;
                    end
                end
            end
            p.cx = 24'(clip(q.sx + ((t * dx + (64'sd1 <<< (T_BITS - 1))) >>> T_BITS),
                            C_MIN, C_MAX));
            p.cy = 24'(clip(q.sy + ((t * dy + (64'sd1 <<< (T_BITS - 1))) >>> T_BITS),
                            C_MIN, C_MAX));
            if (hfs)
            begin
                zr = segment_angle(dx, dy) + 32'h8000;
                hd = longint'($signed(zr[31:16]));
            end
            else
                hd = longint'(q.sh);
            p.deg = 1'b0;
        end
        half_angle_quat(hd, qz, qw);
        p.hd = 16'(hd);
        p.qz = 16'(qz);
        p.qw = 16'(qw);
        return p;
    endfunction

    // Receiver: random stall, plus a long hold-off each time the sender asks
    always @(posedge clk or negedge rst_n)
    begin
        int seen_tok;
        int hold_left;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            seen_tok  = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_tok != seen_tok)
            begin
                seen_tok  = hold_tok;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Check every output transaction against the oldest pending pose
    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_poses.size() == 0)
            begin
                $error("unexpected output transaction");
                err_count++;
            end
            else
            begin
                e = pending_poses.pop_front();
                if (closest_x !== e.cx)
                begin
                    $error("closest_x expected %0d got %0d", e.cx, closest_x);
                    err_count++;
                end
                if (closest_y !== e.cy)
                begin
                    $error("closest_y expected %0d got %0d", e.cy, closest_y);
                    err_count++;
                end
                if (heading !== e.hd)
                begin
                    $error("heading expected %0d got %0d", e.hd, heading);
                    err_count++;
                end
                if (quat_z !== e.qz)
                begin
                    $error("quat_z expected %0d got %0d", e.qz, quat_z);
                    err_count++;
                end
                if (quat_w !== e.qw)
                begin
                    $error("quat_w expected %0d got %0d", e.qw, quat_w);
                    err_count++;
                end
                if (degenerate !== e.deg)
                begin
                    $error("degenerate expected %0d got %0d", e.deg, degenerate);
                    err_count++;
                end
            end
        end
    end

    // Hold until every pending pose has come out, then let the pipe settle
    task automatic drain();
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_heading_sel(input bit v);
        in_valid <= 1'b0;
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        heading_sel = v;
        cfg_valid <= 1'b0;
    endtask

    // Offer one query; an idle gap lowers valid first, never in the same step it rises
    task automatic send_query(input query_t q, input bit typed, input pose_t typed_pose);
        pose_t p;
        int    gap;
        gap = ($urandom_range(99) < tx_idle) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        point_x       <= q.px;
        point_y       <= q.py;
        start_x       <= q.sx;
        start_y       <= q.sy;
        end_x         <= q.ex;
        end_y         <= q.ey;
        start_heading <= q.sh;
        end_heading   <= q.eh;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = project_pose(q, heading_sel);
        if (typed)
        begin
            p.cx  = typed_pose.cx;
            p.cy  = typed_pose.cy;
            p.hd  = typed_pose.hd;
            p.deg = typed_pose.deg;
        end
        pending_poses.insert(pending_poses.size(), p);
    endtask

    function automatic longint coord_any();
        case ($urandom_range(5))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return longint'($signed(24'($urandom_range(2047)))) - 1024;
            default: return longint'($signed(24'($urandom)));
        endcase
    endfunction

    function automatic longint near(input longint base, input int span);
        return clip(base + $signed($urandom_range(2 * span)) - span, C_MIN, C_MAX);
    endfunction

    // Mostly short segments with the point near them; some wide-range noise
    function automatic query_t random_query();
        query_t q;
        int     span;
        span = 1 << $urandom_range(1, 20);
        q.sx = 24'(coord_any());
        q.sy = 24'(coord_any());
        case ($urandom_range(15))
            0:
            begin
                q.ex = q.sx;
                q.ey = q.sy;
            end
            1, 2, 3:
            begin
                q.ex = 24'(coord_any());
                q.ey = 24'(coord_any());
            end
            default:
            begin
                q.ex = 24'(near(q.sx, span));
                q.ey = 24'(near(q.sy, span));
            end
        endcase
        if ($urandom_range(3) == 0)
        begin
            q.px = 24'(coord_any());
            q.py = 24'(coord_any());
        end
        else
        begin
            q.px = 24'(near(q.sx, 2 * span));
            q.py = 24'(near(q.sy, 2 * span));
        end
        q.sh = 16'($urandom);
        q.eh = 16'($urandom);
        return q;
    endfunction

    function automatic row_t mk_row(input bit hfs, input longint px, py, sx, sy, ex, ey,
                                    input longint sh, eh, input bit typed,
                                    input longint cx, cy, hd, input bit deg);
        row_t r;
        r.hfs = hfs;
        r.q.px = 24'(px); r.q.py = 24'(py); r.q.sx = 24'(sx); r.q.sy = 24'(sy);
        r.q.ex = 24'(ex); r.q.ey = 24'(ey); r.q.sh = 16'(sh); r.q.eh = 16'(eh);
        r.typed = typed;
        r.cx = 24'(cx); r.cy = 24'(cy); r.hd = 16'(hd); r.deg = deg;
        return r;
    endfunction

    initial
    begin
        row_t  rows[$];
        pose_t tp;
        int    n;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= 1'b0;
        in_valid      <= 1'b0;
        point_x       <= '0;
        point_y       <= '0;
        start_x       <= '0;
        start_y       <= '0;
        end_x         <= '0;
        end_y         <= '0;
        start_heading <= '0;
        end_heading   <= '0;
        heading_sel   = 1'b1;
        err_count     = 0;
        hold_tok      = 0;
        tx_idle       = 0;
        rx_idle       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; reset value of the register first, then start heading
        rows.insert(rows.size(), mk_row(1, 5, 6, 100, -200, 100, -200, 7, 16384,
                                        1, 100, -200, 16384, 1));
        rows.insert(rows.size(), mk_row(1, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX,
                                        0, -32768, 1, C_MIN, C_MAX, -32768, 1));
        rows.insert(rows.size(), mk_row(1, -8, 0, C_MAX, C_MAX, C_MAX, C_MAX,
                                        -32768, 32767, 1, C_MAX, C_MAX, 32767, 1));
        // direction exactly pi, point behind the start
        rows.insert(rows.size(), mk_row(1, 2000, 0, 1000, 0, 0, 0, 0, 0,
                                        1, 1000, 0, -32768, 0));
        rows.insert(rows.size(), mk_row(1, 5000, 7, 0, 0, 1024, 0, 0, 0,
                                        1, 1024, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, 3, 2048, 0, 0, 0, 4096, 0, 0,
                                        0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, 3, -2048, 0, 0, 0, -4096, 0, 0,
                                        0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, 77, 11, -50, -50, 50, 50, 0, 0,
                                        0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX,
                                        0, 0, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX,
                                        0, 0, 1, C_MAX, C_MAX, 8192, 0));
        rows.insert(rows.size(), mk_row(1, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                        0, 0, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(1, 1, 1, 0, 0, -1, 1, 0, 0,
                                        0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(0, 0, 0, 10, 20, 30, 20, 12345, -1,
                                        1, 10, 20, 12345, 0));
        rows.insert(rows.size(), mk_row(0, 99, 20, 10, 20, 30, 20, -32768, 0,
                                        1, 30, 20, -32768, 0));
        rows.insert(rows.size(), mk_row(0, 20, 55, 10, 20, 30, 20, 32767, 0,
                                        0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(0, 0, 0, -4, 9, -4, 9, 1, -16384,
                                        1, -4, 9, -16384, 1));
        rows.insert(rows.size(), mk_row(0, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX,
                                        -1, 1, 0, 0, 0, 0, 0));
        rows.insert(rows.size(), mk_row(0, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN,
                                        0, 0, 0, 0, 0, 0, 0));

        foreach (rows[i])
        begin
            if (rows[i].hfs != heading_sel)
                write_heading_sel(rows[i].hfs);
            tp.cx  = rows[i].cx;
            tp.cy  = rows[i].cy;
            tp.hd  = rows[i].hd;
            tp.deg = rows[i].deg;
            send_query(rows[i].q, rows[i].typed, tp);
        end

        // Random part in three idle regimes; every 150 queries drain and rewrite
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle = (phase == 0) ? 24 : ((phase == 1) ? 71 : 0);
            rx_idle = (phase == 0) ? 71 : ((phase == 1) ? 24 : 0);
            n = 0;
            while (n < 444)
            begin
                if (n % 150 == 0)
                begin
                    in_valid <= 1'b0;
                    write_heading_sel((n == 0) ? (phase != 1) : $urandom_range(1));
                end
                if (phase == 2 && n == 60)
                    hold_tok++;
                send_query(random_query(), 0, tp);
                n++;
            end
        end
        in_valid <= 1'b0;
        drain();
        if (err_count == 0 && pending_poses.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
